>>> hdl/vbtc_pkg.sv
`default_nettype none

package vbtc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int DIM_REG_W   = 11;
   localparam int LEVEL_W     = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_DENSITY_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_GAINS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_ENABLE        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_WIDTH      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_HEIGHT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_DEPTH      = 3'd5;

   localparam logic [7:0]           THRESHOLD_RESET = 8'd60;
   localparam logic [63:0]          GAINS_RESET     = 64'h0100_0100_0100_0100;
   localparam logic [DIM_REG_W-1:0] DIM_RESET       = 11'd256;
   localparam logic [7:0]           OUTLINE_VALUE   = 8'd110;

   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 2;

   typedef struct packed {
      logic [7:0] voxel;
      logic       volume_start;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       on_box_edge;
   } rsp_type;

   // Classified word handed from the front to the back.
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               on_box_edge;
   } mid_type;

   typedef struct packed {
      logic [7:0]           density_threshold;
      logic [63:0]          channel_gains;
      logic                 box_enable;
      logic [DIM_REG_W-1:0] volume_width;
      logic [DIM_REG_W-1:0] volume_height;
      logic [DIM_REG_W-1:0] volume_depth;
   } cfg_type;

endpackage

`default_nettype wire

>>> hdl/vbtc_fifo.sv
`default_nettype none

module vbtc_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type wr_data,
   output logic          full,
   input  wire logic     pop,
   output item_type      rd_data,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/vbtc_front.sv
`default_nettype none

module vbtc_front #(
   parameter int MAX_DIM       = 1024,
   parameter int BOX_THICKNESS = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire vbtc_pkg::cfg_type cfg,
   input  wire logic             accept,
   input  wire vbtc_pkg::req_type req,
   output vbtc_pkg::mid_type     mid
);

   import vbtc_pkg::*;

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CW    = ((DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W) + 1;

   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in, slc_ff, slc_in;
   logic [POS_W-1:0] col, row, slc;
   logic [CW-1:0]    w_eff, h_eff, d_eff;
   logic [CW-1:0]    col_next, row_next, slc_next;
   logic             col_wrap, row_wrap, slc_wrap;
   logic             near_c, near_r, near_s, on_edge;
   logic [7:0]       v;
   logic [7:0]       diff;

   function automatic logic [CW-1:0] eff_dim(input logic [DIM_REG_W-1:0] d);
      logic [CW-1:0] dx;
      dx = CW'(d);
      if (dx == '0 || dx > CW'(MAX_DIM)) begin
         return CW'(MAX_DIM);
      end
      return dx;
   endfunction

   // An axis is near a face when pos < T or pos > dim - T - 1, i.e. pos + T >= dim.
   function automatic logic near_face(input logic [POS_W-1:0] p, input logic [CW-1:0] dim);
      return (CW'(p) < CW'(BOX_THICKNESS)) || ((CW'(p) + CW'(BOX_THICKNESS)) >= dim);
   endfunction

   always_comb begin
      w_eff = eff_dim(cfg.volume_width);
      h_eff = eff_dim(cfg.volume_height);
      d_eff = eff_dim(cfg.volume_depth);

      col = req.volume_start ? '0 : col_ff;
      row = req.volume_start ? '0 : row_ff;
      slc = req.volume_start ? '0 : slc_ff;

      near_c  = near_face(col, w_eff);
      near_r  = near_face(row, h_eff);
      near_s  = near_face(slc, d_eff);
      on_edge = cfg.box_enable &&
                ((near_c && near_r) || (near_c && near_s) || (near_r && near_s));

      v    = on_edge ? OUTLINE_VALUE : req.voxel;
      diff = (v < cfg.density_threshold) ? 8'd0 : v - cfg.density_threshold;

      mid.level       = diff[7:1];
      mid.on_box_edge = on_edge;

      // Raster advance: the row moves only when the column wraps, and so on.
      col_next = CW'(col) + 1'b1;
      row_next = CW'(row) + 1'b1;
      slc_next = CW'(slc) + 1'b1;
      col_wrap = col_next >= w_eff;
      row_wrap = row_next >= h_eff;
      slc_wrap = slc_next >= d_eff;

      col_in = col_wrap ? '0 : col_next[POS_W-1:0];
      row_in = row;
      slc_in = slc;
      if (col_wrap) begin
         row_in = row_wrap ? '0 : row_next[POS_W-1:0];
         if (row_wrap) begin
            slc_in = slc_wrap ? '0 : slc_next[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         slc_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         slc_ff <= slc_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/vbtc_back.sv
`default_nettype none

module vbtc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [63:0]       gains,
   input  wire logic              mid_empty,
   input  wire vbtc_pkg::mid_type mid,
   output logic                   mid_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output vbtc_pkg::rsp_type      rsp_data
);

   import vbtc_pkg::*;

   logic    out_full;
   rsp_type result;

   // Level times an unsigned 8.8 gain, fraction dropped, clipped to a byte.
   function automatic logic [7:0] scale(input logic [LEVEL_W-1:0] level,
                                        input logic [15:0] gain);
      logic [LEVEL_W+15:0] prod;
      logic [LEVEL_W+7:0]  whole;
      prod  = (LEVEL_W + 16)'(level) * (LEVEL_W + 16)'(gain);
      whole = prod[LEVEL_W+15:8];
      return (whole > (LEVEL_W + 8)'(255)) ? 8'hFF : whole[7:0];
   endfunction

   always_comb begin
      result.red         = scale(mid.level, gains[15:0]);
      result.green       = scale(mid.level, gains[31:16]);
      result.blue        = scale(mid.level, gains[47:32]);
      result.alpha       = scale(mid.level, gains[63:48]);
      result.on_box_edge = mid.on_box_edge;
   end

   assign mid_pop = !mid_empty && !out_full;

   vbtc_fifo #(
      .item_type (rsp_type),
      .DEPTH     (OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_pop),
      .wr_data (result),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

endmodule

`default_nettype wire

>>> hdl/voxel_box_threshold_colorizer_top.sv
// Voxel colorizer with an optional bounding box outline.
// Input words (voxel, volume_start) are pushed with req_push while req_full
// is low; one result word (red, green, blue, alpha, on_box_edge) comes out
// per input word, in order, read with rsp_pop while rsp_empty is low.
// Registers are written through csr_valid/csr_index/csr_data; csr_ready is
// always high, and registers should only change while no word is in flight.
// Accepted words pass through the middle queue into the result queue, whose
// head drives rsp_data. Throughput: one word per cycle while rsp_pop is high.
// The front stage tracks the raster position and classifies each voxel in
// the accept cycle; a two-word queue feeds the back stage, whose four
// small multipliers write a two-word result queue.
// Reset clears the position counters, both queues and loads the register
// defaults (threshold 60, gains 1.0, box off, 256 cubed volume).
// When the receiver stalls, the result queue fills, then the middle queue,
// and req_full rises; no word is dropped.
`default_nettype none

module voxel_box_threshold_colorizer_top #(
   parameter int MAX_DIM       = 1024,
   parameter int BOX_THICKNESS = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire vbtc_pkg::req_type                    req_data,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output vbtc_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [vbtc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [vbtc_pkg::CSR_DATA_W-1:0]      csr_data
);

   import vbtc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   mid_type mid_wr, mid_rd;
   logic    accept, mid_full, mid_empty, mid_pop;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;
   assign req_full  = mid_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DENSITY_THRESHOLD: cfg_in.density_threshold = csr_data[7:0];
            CSR_CHANNEL_GAINS:     cfg_in.channel_gains     = csr_data;
            CSR_BOX_ENABLE:        cfg_in.box_enable        = csr_data[0];
            CSR_VOLUME_WIDTH:      cfg_in.volume_width      = csr_data[DIM_REG_W-1:0];
            CSR_VOLUME_HEIGHT:     cfg_in.volume_height     = csr_data[DIM_REG_W-1:0];
            CSR_VOLUME_DEPTH:      cfg_in.volume_depth      = csr_data[DIM_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.density_threshold <= THRESHOLD_RESET;
         cfg_ff.channel_gains     <= GAINS_RESET;
         cfg_ff.box_enable        <= 1'b0;
         cfg_ff.volume_width      <= DIM_RESET;
         cfg_ff.volume_height     <= DIM_RESET;
         cfg_ff.volume_depth      <= DIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vbtc_front #(
      .MAX_DIM       (MAX_DIM),
      .BOX_THICKNESS (BOX_THICKNESS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .req    (req_data),
      .mid    (mid_wr)
   );

   vbtc_fifo #(
      .item_type (mid_type),
      .DEPTH     (MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (mid_wr),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_rd),
      .empty   (mid_empty)
   );

   vbtc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .gains     (cfg_ff.channel_gains),
      .mid_empty (mid_empty),
      .mid       (mid_rd),
      .mid_pop   (mid_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // A word entering an empty block reaches the result ports through the middle and result queues.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept && mid_empty && rsp_empty |=> ##1 !rsp_empty)
      else $error("accepted word did not reach the result queue");

   // The outline flag can only be set while the outline is enabled.
   a_edge_enabled: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.on_box_edge |-> cfg_ff.box_enable)
      else $error("outline flag set with the box disabled");

   // An outline voxel at or below the threshold gives a black, clear word.
   a_edge_dark: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.on_box_edge && cfg_ff.density_threshold >= OUTLINE_VALUE
      |-> rsp_data.red == 8'd0 && rsp_data.green == 8'd0 &&
          rsp_data.blue == 8'd0 && rsp_data.alpha == 8'd0)
      else $error("outline voxel below threshold produced color");

endmodule

`default_nettype wire

>>> verif/tb_voxel_box_threshold_colorizer_top.sv
module tb_voxel_box_threshold_colorizer_top;
   import vbtc_pkg::*;

   localparam int MAX_DIM        = 1024;
   localparam int BOX_THICKNESS  = 4;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;

   // Indexes that map to no register; writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   logic                   req_full;
   req_type                req_data  = '0;
   logic                   rsp_empty;
   logic                   rsp_pop   = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;

   // Shadow copy of the registers and of the raster position counters.
   cfg_type shadow_cfg;
   int      col_pos   = 0;
   int      row_pos   = 0;
   int      slice_pos = 0;

   rsp_type pending_colors[$];
   int      voxels_in    = 0;
   int      colors_out   = 0;
   int      outline_hits = 0;
   int      mismatches   = 0;
   int      quiet_cycles = 0;

   always #5 clock = ~clock;

   voxel_box_threshold_colorizer_top #(
      .MAX_DIM       (MAX_DIM),
      .BOX_THICKNESS (BOX_THICKNESS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   function automatic int eff_dim(logic [DIM_REG_W-1:0] d);
      return (d == 0 || d > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   function automatic bit near_face(int pos, int dim);
      return pos < BOX_THICKNESS || pos > dim - BOX_THICKNESS - 1;
   endfunction

   function automatic rsp_type colorize(req_type w);
      rsp_type    r;
      int         wd;
      int         ht;
      int         dp;
      int         level;
      int         prod;
      int         chan [4];
      logic [7:0] v;
      wd = eff_dim(shadow_cfg.volume_width);
      ht = eff_dim(shadow_cfg.volume_height);
      dp = eff_dim(shadow_cfg.volume_depth);
      if (w.volume_start) begin
         col_pos   = 0;
         row_pos   = 0;
         slice_pos = 0;
      end
      r = '0;
      v = w.voxel;
      if (shadow_cfg.box_enable && (int'(near_face(col_pos, wd)) + int'(near_face(row_pos, ht))
                                    + int'(near_face(slice_pos, dp)) >= 2)) begin
         v = OUTLINE_VALUE;
         r.on_box_edge = 1'b1;
      end
      level = (v < shadow_cfg.density_threshold) ? 0
            : (int'(v) - int'(shadow_cfg.density_threshold)) / 2;
      for (int i = 0; i < 4; i++) begin
         prod    = (level * int'(shadow_cfg.channel_gains[16*i +: 16])) / 256;
         chan[i] = (prod > 255) ? 255 : prod;
      end
      r.red   = 8'(chan[0]);
      r.green = 8'(chan[1]);
      r.blue  = 8'(chan[2]);
      r.alpha = 8'(chan[3]);
      // A counter left beyond a shrunk dimension wraps on its next advance.
      if (col_pos + 1 >= wd) begin
         col_pos = 0;
         if (row_pos + 1 >= ht) begin
            row_pos   = 0;
            slice_pos = (slice_pos + 1 >= dp) ? 0 : slice_pos + 1;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
      return r;
   endfunction

   function automatic void note_failure(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      case ($urandom_range(11))
         0:       return 64'd0;
         1:       return 64'(MAX_DIM);
         2:       return 64'($urandom_range(2047, MAX_DIM + 1));
         default: return 64'($urandom_range(12, 1));
      endcase
   endfunction

   // Tracks every handshake: register writes update the shadow, accepted voxels
   // are colorized into the expected queue and each popped word is checked.
   always @(posedge clock) begin
      rsp_type want;
      bit      moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               CSR_DENSITY_THRESHOLD: shadow_cfg.density_threshold = csr_data[7:0];
               CSR_CHANNEL_GAINS:     shadow_cfg.channel_gains     = csr_data;
               CSR_BOX_ENABLE:        shadow_cfg.box_enable        = csr_data[0];
               CSR_VOLUME_WIDTH:      shadow_cfg.volume_width      = csr_data[DIM_REG_W-1:0];
               CSR_VOLUME_HEIGHT:     shadow_cfg.volume_height     = csr_data[DIM_REG_W-1:0];
               CSR_VOLUME_DEPTH:      shadow_cfg.volume_depth      = csr_data[DIM_REG_W-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            moved = 1'b1;
            want  = colorize(req_data);
            pending_colors.push_back(want);
            voxels_in++;
            if (want.on_box_edge) outline_hits++;
         end
         if (rsp_pop && !rsp_empty) begin
            moved = 1'b1;
            if (pending_colors.size() == 0) begin
               note_failure($sformatf("unexpected word r=%0d g=%0d b=%0d a=%0d edge=%0b",
                  rsp_data.red, rsp_data.green, rsp_data.blue, rsp_data.alpha,
                  rsp_data.on_box_edge));
            end else begin
               want = pending_colors.pop_front();
               if (rsp_data !== want) begin
                  note_failure($sformatf(
                     "word %0d: expected r=%0d g=%0d b=%0d a=%0d edge=%0b, got r=%0d g=%0d b=%0d a=%0d edge=%0b",
                     colors_out, want.red, want.green, want.blue, want.alpha, want.on_box_edge,
                     rsp_data.red, rsp_data.green, rsp_data.blue, rsp_data.alpha,
                     rsp_data.on_box_edge));
               end
               colors_out++;
            end
         end
      end
      quiet_cycles = (moved || reset) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d words outstanding",
                  quiet_cycles, pending_colors.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_voxel(input logic [7:0] voxel, input logic volume_start);
      req_type w;
      w.voxel        = voxel;
      w.volume_start = volume_start;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_data <= w;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops pushing and lets every outstanding word drain before registers move.
   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_colors.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_defaults();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_voxel(8'd255, 1'b1);
      send_voxel(8'd0, 1'b0);
      send_voxel(8'd61, 1'b0);
      send_voxel(8'd62, 1'b0);
      wait_idle();
   endtask

   task automatic test_register_extremes();
      write_csr(CSR_DENSITY_THRESHOLD, 64'd0);
      // Red saturates, green is off, blue is one half, alpha is unity.
      write_csr(CSR_CHANNEL_GAINS, 64'h0100_0080_0000_FFFF);
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, '1);
      send_voxel(8'd255, 1'b1);
      send_voxel(8'd1, 1'b0);
      wait_idle();
      write_csr(CSR_DENSITY_THRESHOLD, '1);
      send_voxel(8'd255, 1'b0);
      send_voxel(8'd254, 1'b0);
      wait_idle();
   endtask

   task automatic test_box_small();
      write_csr(CSR_BOX_ENABLE, '1);
      write_csr(CSR_DENSITY_THRESHOLD, 64'd20);
      write_csr(CSR_VOLUME_WIDTH, '1);
      write_csr(CSR_VOLUME_HEIGHT, 64'd1);
      // Low eleven bits clear: a zero depth stands for the largest volume.
      write_csr(CSR_VOLUME_DEPTH, 64'hFFFF_FFFF_FFFF_F800);
      send_voxel(8'd3, 1'b1);
      send_voxel(8'd200, 1'b0);
      wait_idle();
      write_csr(CSR_VOLUME_WIDTH, 64'd1);
      write_csr(CSR_VOLUME_HEIGHT, 64'd2);
      write_csr(CSR_VOLUME_DEPTH, 64'd2);
      send_voxel(8'd110, 1'b0);
      send_voxel(8'd0, 1'b0);
      wait_idle();
   endtask

   task automatic test_shrunk_width();
      // With one-voxel rows and slices every word steps the slice counter.
      write_csr(CSR_VOLUME_WIDTH, 64'd1);
      write_csr(CSR_VOLUME_HEIGHT, 64'd1);
      write_csr(CSR_VOLUME_DEPTH, 64'd12);
      send_voxel(8'd90, 1'b1);
      repeat (4) send_voxel(8'd140, 1'b0);
      wait_idle();
      // Slice 5 is interior, row 0 is on a face, so the column decides.
      write_csr(CSR_VOLUME_WIDTH, 64'd12);
      write_csr(CSR_VOLUME_HEIGHT, 64'd12);
      repeat (5) send_voxel(8'd180, 1'b0);
      wait_idle();
      // The column counter now sits beyond the new width.
      write_csr(CSR_VOLUME_WIDTH, 64'd3);
      send_voxel(8'd33, 1'b0);
      send_voxel(8'd77, 1'b0);
      wait_idle();
   endtask

   task automatic test_full_width_row();
      send_idle_pct = 23;
      stall_pct     = 23;
      write_csr(CSR_DENSITY_THRESHOLD, 64'd0);
      write_csr(CSR_CHANNEL_GAINS, GAINS_RESET);
      write_csr(CSR_BOX_ENABLE, 64'd1);
      write_csr(CSR_VOLUME_WIDTH, 64'd1);
      write_csr(CSR_VOLUME_HEIGHT, 64'd12);
      write_csr(CSR_VOLUME_DEPTH, 64'd12);
      // Step down to row 6 so that only the column can add a second face.
      send_voxel(8'($urandom_range(255)), 1'b1);
      repeat (5) send_voxel(8'($urandom_range(255)), 1'b0);
      wait_idle();
      write_csr(CSR_VOLUME_WIDTH, 64'(MAX_DIM));
      repeat (MAX_DIM + 6) send_voxel(8'($urandom_range(255)), 1'b0);
      wait_idle();
   endtask

   task automatic test_random_volumes(input int send_idle, input int stall, input int n_items);
      int                    sent;
      int                    run_len;
      logic [CSR_DATA_W-1:0] gains;
      send_idle_pct = send_idle;
      stall_pct     = stall;
      sent          = 0;
      while (sent < n_items) begin
         wait_idle();
         for (int c = 0; c < 4; c++) begin
            case ($urandom_range(5))
               0:       gains[16*c +: 16] = 16'h0000;
               1:       gains[16*c +: 16] = 16'hFFFF;
               2:       gains[16*c +: 16] = 16'($urandom);
               default: gains[16*c +: 16] = 16'($urandom_range(16'h0300));
            endcase
         end
         write_csr(CSR_DENSITY_THRESHOLD, ($urandom_range(7) == 0) ? 64'd0
                                        : ($urandom_range(7) == 0) ? 64'd255
                                        : 64'($urandom_range(255)));
         write_csr(CSR_CHANNEL_GAINS, gains);
         write_csr(CSR_BOX_ENABLE, 64'($urandom_range(3) != 0));
         write_csr(CSR_VOLUME_WIDTH, pick_dim());
         write_csr(CSR_VOLUME_HEIGHT, pick_dim());
         write_csr(CSR_VOLUME_DEPTH, pick_dim());
         run_len = $urandom_range(60, 8);
         // Most runs open a fresh volume; a stray start now and then restarts it.
         for (int k = 0; k < run_len; k++) begin
            send_voxel(8'($urandom_range(255)),
                       (k == 0) ? ($urandom_range(3) != 0) : ($urandom_range(49) == 0));
         end
         sent += run_len;
      end
      wait_idle();
   endtask

   initial begin
      shadow_cfg = '{THRESHOLD_RESET, GAINS_RESET, 1'b0, DIM_RESET, DIM_RESET, DIM_RESET};
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_defaults();
      test_register_extremes();
      test_box_small();
      test_shrunk_width();
      test_random_volumes(0, 0, 170);
      test_random_volumes(52, 0, 170);
      test_random_volumes(0, 52, 170);
      test_random_volumes(23, 23, 170);
      test_full_width_row();

      wait_idle();
      $display("Checked %0d of %0d voxel words, %0d of them on the box outline.",
               colors_out, voxels_in, outline_hits);
      $display("Traffic ran gap-free, with sender gaps, receiver stalls and both; %0d mismatches.",
               mismatches);
      if (mismatches == 0 && pending_colors.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
